@@ design/sdrm_pkg.sv @@
package sdrm_pkg;

  localparam int DataW = 32;
  localparam int RadW  = 31;
  localparam int TrigW = 18;
  localparam int CfgW  = 31;
  localparam int CfgIdxW = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegThreeD   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegInvRad   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegInvLat   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegInvLon   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRadPts   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLatPts   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegLonPts   = 3'd6;

  // divider operand widths
  localparam int NumW = 64;
  localparam int DenW = 50;

  typedef struct packed {
    logic [31:0] u_outer;
    logic [31:0] u_inner;
    logic [31:0] u_centre;
    logic [31:0] v_next;
    logic [31:0] v_prev;
    logic [31:0] v_centre;
    logic [31:0] w_east;
    logic [31:0] w_west;
    logic [30:0] radius;
    logic [17:0] sin_colat;
    logic [17:0] cos_colat;
  } in_item_t;

  typedef struct packed {
    logic [31:0] residual;
    logic [31:0] max_residual;
    logic [5:0]  max_radial_index;
    logic [7:0]  max_lat_index;
    logic [8:0]  max_lon_index;
    logic        sweep_done;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_Q0, S_Q1, S_Q2, S_Q3, S_SUM, S_PEAK, S_OUT
  } state_t;

  // divider control
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

  function automatic logic signed [63:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

endpackage

@@ design/sdrm_if.sv @@
interface sdrm_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/sdrm_div.sv @@
// Signed restoring divider, one quotient bit per cycle, truncating toward
// zero, saturated to 32 bits, zero divisor saturates by numerator sign.
module sdrm_div import sdrm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [NumW-1:0] num,
  input  logic signed [DenW-1:0] den,
  output div_ctl_t               ctl,
  output logic signed [31:0]     quo
);
  localparam int CntW = $clog2(NumW + 1);

  logic [DenW-1:0] dabs;
  logic [NumW-1:0] q;
  logic [DenW:0]   rem;
  logic [CntW-1:0] cnt;
  logic            neg, busy, done, dzero, nneg, nzero;
  logic [DenW:0]   trial;
  logic signed [64:0] sq;

  assign trial = {rem[DenW-1:0], q[NumW-1]} - {1'b0, dabs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(NumW);
        q    <= num[NumW-1] ? NumW'(-num) : NumW'(num);
        dabs <= den[DenW-1] ? DenW'(-den) : DenW'(den);
        rem  <= '0;
        neg  <= num[NumW-1] ^ den[DenW-1];
        dzero <= (den == '0);
        nneg  <= num[NumW-1];
        nzero <= (num == '0);
      end else if (busy) begin
        if (trial[DenW]) begin
          rem <= {rem[DenW-1:0], q[NumW-1]};
          q   <= {q[NumW-2:0], 1'b0};
        end else begin
          rem <= trial;
          q   <= {q[NumW-2:0], 1'b1};
        end
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // sign and saturation of the magnitude quotient
  always_comb begin
    sq = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (dzero) begin
      quo = nzero ? 32'sd0 : (nneg ? 32'h8000_0000 : 32'h7FFF_FFFF);
    end else if (sq > 65'sd2147483647) begin
      quo = 32'h7FFF_FFFF;
    end else if (sq < -65'sd2147483648) begin
      quo = 32'h8000_0000;
    end else begin
      quo = sq[31:0];
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy;
  assign ctl.done  = done;
endmodule

@@ design/spherical_divergence_residual_max_unit.sv @@
// An accepted item passes through a multiply step, four quotients on the
// shared bit-serial divider (start, 64 iterations, done), then sum, peak
// and output steps. A new item is accepted only once the current one has
// left the output step; a result still waiting holds the next item in the
// output step until it is taken.
// Synchronous active-high reset restores configuration registers to defaults,
// clears the peak and sets the grid counters to the first interior point.
module spherical_divergence_residual_max_unit import sdrm_pkg::*; #(
  parameter int MAX_RADIAL_POINTS = 64,
  parameter int MAX_LAT_POINTS    = 256,
  parameter int MAX_LON_POINTS    = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  sdrm_if.sink               in_ch,
  sdrm_if.source             out_ch
);
  localparam int RW = $clog2(MAX_RADIAL_POINTS);
  localparam int LW = $clog2(MAX_LAT_POINTS);
  localparam int OW = $clog2(MAX_LON_POINTS);

  // configuration
  logic        three_d_mode;
  logic [30:0] inv_rad, inv_lat, inv_lon;
  logic [6:0]  rad_pts;
  logic [8:0]  lat_pts;
  logic [9:0]  lon_pts;

  always_ff @(posedge clk) begin
    if (rst) begin
      three_d_mode <= 1'b1;
      inv_rad <= 31'd65536;
      inv_lat <= 31'd65536;
      inv_lon <= 31'd65536;
      rad_pts <= 7'd41;
      lat_pts <= 9'd181;
      lon_pts <= 10'd361;
    end else if (cfg_we) begin
      case (cfg_index)
        RegThreeD: three_d_mode <= cfg_data[0];
        RegInvRad: inv_rad <= cfg_data;
        RegInvLat: inv_lat <= cfg_data;
        RegInvLon: inv_lon <= cfg_data;
        RegRadPts: rad_pts <= cfg_data[6:0];
        RegLatPts: lat_pts <= cfg_data[8:0];
        RegLonPts: lon_pts <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  in_item_t item;
  logic three;
  logic signed [63:0] dudr, dvdthe, dwdphi;
  logic signed [DenW-1:0] rms;
  logic signed [63:0] sum;
  logic signed [31:0] res;
  logic signed [31:0] best_residual;
  logic [RW-1:0] cur_radial, best_radial;
  logic [LW-1:0] cur_lat, best_lat;
  logic [OW-1:0] cur_lon, best_lon;
  out_item_t obuf;
  logic obuf_valid;
  logic done_r;

  // shared divider
  logic                   div_start;
  logic signed [NumW-1:0] div_num;
  logic signed [DenW-1:0] div_den;
  div_ctl_t               div_ctl;
  logic signed [31:0]     div_quo;
  logic                   div_issued;

  sdrm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .ctl(div_ctl), .quo(div_quo)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_next = S_MUL;
      S_MUL:  state_next = S_Q0;
      S_Q0:   if (div_ctl.done) state_next = S_Q1;
      S_Q1:   if (div_ctl.done) state_next = S_Q2;
      S_Q2:   if (div_ctl.done) state_next = S_Q3;
      S_Q3:   if (div_ctl.done) state_next = S_SUM;
      S_SUM:  state_next = S_PEAK;
      S_PEAK: state_next = S_OUT;
      S_OUT:  if (!obuf_valid || out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // divider operands per quotient step
  always_comb begin
    div_num = '0;
    div_den = '0;
    case (state)
      S_Q0: begin
        div_num = dvdthe <<< 16;
        div_den = DenW'($signed({1'b0, item.radius}));
      end
      S_Q1: begin
        div_num = 64'($signed(item.cos_colat)) * 64'($signed(item.v_centre));
        div_den = rms;
      end
      S_Q2: begin
        div_num = dwdphi <<< 16;
        div_den = rms;
      end
      S_Q3: begin
        div_num = 64'($signed(item.u_centre)) <<< 17;
        div_den = DenW'($signed({1'b0, item.radius}));
      end
      default: ;
    endcase
    div_start = !div_issued && (state == S_Q0 || state == S_Q1 ||
                                state == S_Q2 || state == S_Q3);
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = obuf_valid;
  assign out_ch.data  = obuf;

  function automatic logic signed [63:0] deriv(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic [30:0] inv);
    logic signed [63:0] p;
    p = (64'(a) - 64'(b)) * 64'($signed({1'b0, inv}));
    return sat32(p >>> 16);
  endfunction

  logic [RW:0] lr;
  logic [LW:0] ll;
  logic [OW:0] lo;
  always_comb begin
    lr = (RW+1)'((int'(rad_pts) > MAX_RADIAL_POINTS ? MAX_RADIAL_POINTS
         : (int'(rad_pts) < 3 ? 3 : int'(rad_pts))) - 2);
    ll = (LW+1)'((int'(lat_pts) > MAX_LAT_POINTS ? MAX_LAT_POINTS
         : (int'(lat_pts) < 3 ? 3 : int'(lat_pts))) - 2);
    lo = (OW+1)'((int'(lon_pts) > MAX_LON_POINTS ? MAX_LON_POINTS
         : (int'(lon_pts) < 3 ? 3 : int'(lon_pts))) - 2);
  end

  logic [63:0] abs_res, abs_best;
  logic done_flag;

  // magnitudes for the peak compare and the end-of-sweep flag
  always_comb begin
    abs_res  = res[31] ? -64'(res) : 64'(res);
    abs_best = best_residual[31] ? -64'(best_residual) : 64'(best_residual);
    done_flag = ({1'b0, cur_lon} >= lo) && ({1'b0, cur_lat} >= ll) &&
                (!three || ({1'b0, cur_radial} >= lr));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      obuf_valid <= 1'b0;
      div_issued <= 1'b0;
      best_residual <= '0;
      best_radial <= '0;
      best_lat <= '0;
      best_lon <= '0;
      cur_radial <= RW'(1);
      cur_lat <= LW'(1);
      cur_lon <= OW'(1);
    end else begin
      state <= state_next;
      if (out_ch.valid && out_ch.ready && state != S_OUT) obuf_valid <= 1'b0;
      if (div_start) div_issued <= 1'b1;
      if (div_ctl.done) div_issued <= 1'b0;
      case (state)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          item  <= in_ch.data;
          three <= three_d_mode;
        end
        S_MUL: begin
          dudr   <= deriv(item.u_outer, item.u_inner, inv_rad);
          dvdthe <= deriv(item.v_next, item.v_prev, inv_lat);
          dwdphi <= deriv(item.w_east, item.w_west, inv_lon);
          rms    <= DenW'((64'($signed({1'b0, item.radius})) *
                           64'($signed(item.sin_colat))) >>> 16);
          sum    <= '0;
        end
        S_Q0, S_Q1, S_Q2: if (div_ctl.done) sum <= sum + 64'(div_quo);
        S_Q3: if (div_ctl.done) begin
          if (three) sum <= sum + 64'(div_quo) + dudr;
        end
        S_SUM: res <= 32'(sat32(sum));
        S_PEAK: begin
          if (abs_res > abs_best) begin
            best_residual <= res;
            best_radial <= three ? cur_radial : '0;
            best_lat <= cur_lat;
            best_lon <= cur_lon;
          end
          if ({1'b0, cur_lon} >= lo) begin
            cur_lon <= OW'(1);
            if ({1'b0, cur_lat} >= ll) begin
              cur_lat <= LW'(1);
              if (three) begin
                if ({1'b0, cur_radial} >= lr) cur_radial <= RW'(1);
                else cur_radial <= cur_radial + 1'b1;
              end
            end else cur_lat <= cur_lat + 1'b1;
          end else cur_lon <= cur_lon + 1'b1;
          done_r <= done_flag;
        end
        S_OUT: if (!obuf_valid || out_ch.ready) begin
          obuf.residual <= res;
          obuf.max_residual <= best_residual;
          obuf.max_radial_index <= 6'(best_radial);
          obuf.max_lat_index <= 8'(best_lat);
          obuf.max_lon_index <= 9'(best_lon);
          obuf.sweep_done <= done_r;
          obuf_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

@@ design/sdrm_checker.sv @@
module sdrm_checker import sdrm_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] out_residual,
  input logic [31:0] out_max
);
  // one item at a time: no new accept right after an accept
  a_gap: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("back to back accept");
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_residual)))
    else $error("result dropped");
  // no result leaves the reset state
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
  // peak is nonzero whenever the item's residual is nonzero
  a_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_max != 32'h0 || out_residual == 32'h0))
    else $error("peak below residual");
endmodule

bind spherical_divergence_residual_max_unit sdrm_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_residual(out_ch.data.residual), .out_max(out_ch.data.max_residual)
);

@@ tb/sv/spherical_divergence_residual_max_unit_checker.sv @@
module spherical_divergence_residual_max_unit_checker import sdrm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  in_item_t           in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  out_item_t          out_data,
  output int                 fail_count,
  output int                 pending
);

  localparam longint Max32 = 64'sd2147483647;
  localparam longint Min32 = -64'sd2147483648;

  // shadow registers
  logic        mode_3d;
  logic [30:0] inv_rad, inv_lat, inv_lon;
  logic [6:0]  rad_pts;
  logic [8:0]  lat_pts;
  logic [9:0]  lon_pts;

  // running peak and grid position
  longint      peak_res;
  logic [31:0] peak_r, peak_t, peak_p;
  logic [31:0] pos_r, pos_t, pos_p;

  out_item_t residual_q[$];

  function automatic longint clip32(input longint x);
    if (x > Max32) return Max32;
    if (x < Min32) return Min32;
    return x;
  endfunction

  // floor of x / 2^16
  function automatic longint shr16(input longint x);
    return x >>> 16;
  endfunction

  function automatic longint divq(input longint num, input longint den);
    if (den == 0) return (num > 0) ? Max32 : (num < 0) ? Min32 : 0;
    return clip32(num / den);
  endfunction

  function automatic longint absl(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic logic [31:0] last_idx(input logic [31:0] pts, input logic [31:0] lim);
    logic [31:0] p;
    p = pts;
    if (p > lim) p = lim;
    if (p < 3) p = 3;
    return p - 2;
  endfunction

  // compute the expected result for one grid point and advance the sweep
  function automatic out_item_t predict_residual(input in_item_t it);
    out_item_t   o;
    longint      uo, ui, uc, vn, vp, vc, we, ww, rad, sn, cs;
    longint      dv, dw, du, rms, sum, res;
    logic [31:0] lr, ll, lo;
    logic        done;
    uo = longint'($signed(it.u_outer));  ui = longint'($signed(it.u_inner));
    uc = longint'($signed(it.u_centre)); vn = longint'($signed(it.v_next));
    vp = longint'($signed(it.v_prev));   vc = longint'($signed(it.v_centre));
    we = longint'($signed(it.w_east));   ww = longint'($signed(it.w_west));
    rad = longint'({33'd0, it.radius});
    sn = longint'($signed(it.sin_colat)); cs = longint'($signed(it.cos_colat));
    done = 1'b0;
    dv = clip32(shr16((vn - vp) * longint'({33'd0, inv_lat})));
    dw = clip32(shr16((we - ww) * longint'({33'd0, inv_lon})));
    rms = shr16(rad * sn);
    sum = divq(dv * 65536, rad) + divq(cs * vc, rms) + divq(dw * 65536, rms);
    if (mode_3d) begin
      du = clip32(shr16((uo - ui) * longint'({33'd0, inv_rad})));
      sum += du + divq(2 * uc * 65536, rad);
    end
    res = clip32(sum);
    if (absl(res) > absl(peak_res)) begin
      peak_res = res;
      peak_r = mode_3d ? pos_r : 0;
      peak_t = pos_t;
      peak_p = pos_p;
    end
    lr = last_idx(rad_pts, 64);
    ll = last_idx(lat_pts, 256);
    lo = last_idx(lon_pts, 512);
    if (pos_p >= lo) begin
      pos_p = 1;
      if (pos_t >= ll) begin
        pos_t = 1;
        if (!mode_3d) done = 1'b1;
        else if (pos_r >= lr) begin
          pos_r = 1;
          done = 1'b1;
        end else pos_r++;
      end else pos_t++;
    end else pos_p++;
    o.residual = res[31:0];
    o.max_residual = peak_res[31:0];
    o.max_radial_index = peak_r[5:0];
    o.max_lat_index = peak_t[7:0];
    o.max_lon_index = peak_p[8:0];
    o.sweep_done = done;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      mode_3d <= 1'b1;
      inv_rad <= 31'd65536; inv_lat <= 31'd65536; inv_lon <= 31'd65536;
      rad_pts <= 7'd41; lat_pts <= 9'd181; lon_pts <= 10'd361;
      peak_res = 0; peak_r = 0; peak_t = 0; peak_p = 0;
      pos_r = 1; pos_t = 1; pos_p = 1;
      residual_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegThreeD: mode_3d <= cfg_data[0];
          RegInvRad: inv_rad <= cfg_data[30:0];
          RegInvLat: inv_lat <= cfg_data[30:0];
          RegInvLon: inv_lon <= cfg_data[30:0];
          RegRadPts: rad_pts <= cfg_data[6:0];
          RegLatPts: lat_pts <= cfg_data[8:0];
          RegLonPts: lon_pts <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) residual_q.push_back(predict_residual(in_data));
      if (out_valid && out_ready) begin
        if (residual_q.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          out_item_t e;
          e = residual_q.pop_front();
          if (out_data.residual !== e.residual)
            report_mismatch("residual", $signed(out_data.residual), $signed(e.residual));
          if (out_data.max_residual !== e.max_residual)
            report_mismatch("max_residual", $signed(out_data.max_residual),
                            $signed(e.max_residual));
          if (out_data.max_radial_index !== e.max_radial_index)
            report_mismatch("max_radial_index", out_data.max_radial_index,
                            e.max_radial_index);
          if (out_data.max_lat_index !== e.max_lat_index)
            report_mismatch("max_lat_index", out_data.max_lat_index, e.max_lat_index);
          if (out_data.max_lon_index !== e.max_lon_index)
            report_mismatch("max_lon_index", out_data.max_lon_index, e.max_lon_index);
          if (out_data.sweep_done !== e.sweep_done)
            report_mismatch("sweep_done", out_data.sweep_done, e.sweep_done);
        end
      end
    end
    pending = residual_q.size();
  end

endmodule

@@ tb/sv/spherical_divergence_residual_max_unit_tb.sv @@
module spherical_divergence_residual_max_unit_tb;
  import sdrm_pkg::*;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;
  int                 fail_count;
  int                 pending;
  int                 hold_cycles;

  sdrm_if #(.payload_t(in_item_t))  in_ch  (clk);
  sdrm_if #(.payload_t(out_item_t)) out_ch (clk);

  spherical_divergence_residual_max_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  spherical_divergence_residual_max_unit_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // mostly short gaps, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 400);
  endfunction

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 65536 * 8) - 65536 * 4;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [17:0] rand_trig();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 18'd0;
    if (r == 1) return 18'sd65536;
    if (r == 2) return -18'sd65536;
    return 18'($urandom_range(0, 131072) - 65536);
  endfunction

  function automatic in_item_t rand_point();
    in_item_t it;
    int r;
    it.u_outer = rand_vel(); it.u_inner = rand_vel(); it.u_centre = rand_vel();
    it.v_next = rand_vel(); it.v_prev = rand_vel(); it.v_centre = rand_vel();
    it.w_east = rand_vel(); it.w_west = rand_vel();
    r = $urandom_range(0, 9);
    if (r == 0) it.radius = 31'd1;
    else if (r == 1) it.radius = 31'h7fff_ffff;
    else if (r < 6) it.radius = 31'($urandom_range(65536, 65536 * 4));
    else it.radius = 31'($urandom());
    it.sin_colat = rand_trig();
    it.cos_colat = rand_trig();
    return it;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_point(input in_item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // drain all expected results, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) send_point(rand_point());
  endtask

  task automatic random_grid();
    write_reg(RegThreeD, CfgW'($urandom_range(0, 1)));
    write_reg(RegInvRad, ($urandom_range(0, 3) == 0) ? CfgW'($urandom()) :
              CfgW'($urandom_range(0, 65536 * 4)));
    write_reg(RegInvLat, ($urandom_range(0, 3) == 0) ? CfgW'($urandom()) :
              CfgW'($urandom_range(0, 65536 * 4)));
    write_reg(RegInvLon, ($urandom_range(0, 3) == 0) ? CfgW'($urandom()) :
              CfgW'($urandom_range(0, 65536 * 4)));
    write_reg(RegRadPts, CfgW'($urandom_range(0, 6)));
    write_reg(RegLatPts, CfgW'($urandom_range(0, 7)));
    write_reg(RegLonPts, CfgW'($urandom_range(0, 9)));
  endtask

  // receiver: random stalls, plus one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    hold_cycles = 0;
    @(negedge rst);
    forever begin
      int g;
      g = gap_len();
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // stimulus
  initial begin
    in_item_t it;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: small grid, extremes, zero divisors, saturation, 2D mode
    write_reg(RegRadPts, 3);
    write_reg(RegLatPts, 4);
    write_reg(RegLonPts, 4);
    it = '0; it.radius = 31'd65536; it.sin_colat = 18'sd65536;
    send_point(it);
    it.u_outer = 32'h7fff_ffff; it.u_inner = 32'h8000_0000; it.u_centre = 32'h7fff_ffff;
    send_point(it);
    it = '1; it.sin_colat = 18'sd0;
    send_point(it);
    it = '0; it.radius = 31'd1; it.v_centre = 32'd1; it.cos_colat = -18'sd65536;
    it.sin_colat = 18'sd0;
    send_point(it);
    it.v_centre = 32'h8000_0000;
    send_point(it);
    it = '0; it.radius = 31'd100; it.sin_colat = 18'sd1;
    it.w_east = 32'h8000_0000; it.w_west = 32'h7fff_ffff;
    send_point(it);
    for (int i = 0; i < 6; i++) send_point(rand_point());
    drain();
    write_reg(RegThreeD, 0);
    write_reg(RegInvRad, 31'h7fff_ffff);
    write_reg(RegInvLat, 31'h7fff_ffff);
    write_reg(RegInvLon, 0);
    write_reg(RegLatPts, 0);
    write_reg(RegLonPts, 10'h3ff);
    for (int i = 0; i < 8; i++) send_point(rand_point());
    drain();

    // resize the grid mid-sweep: fewer longitudes, more latitudes and radial points
    write_reg(RegThreeD, 1);
    write_reg(RegInvLat, 65536);
    write_reg(RegInvLon, 65536);
    write_reg(RegRadPts, 7'h7f);
    write_reg(RegLatPts, 9'h1ff);
    write_reg(RegLonPts, 9);
    random_phase(20);
    drain();

    // long receiver hold-off while the sender keeps offering
    write_reg(RegLonPts, 5);
    hold_cycles = 3000;
    random_phase(40);
    drain();

    // random phases with varied settings
    for (int p = 0; p < 16; p++) begin
      random_grid();
      random_phase(48);
      drain();
    end

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #100000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
design/sdrm_pkg.sv
design/sdrm_if.sv
design/sdrm_div.sv
design/spherical_divergence_residual_max_unit.sv
design/sdrm_checker.sv
tb/sv/spherical_divergence_residual_max_unit_checker.sv
tb/sv/spherical_divergence_residual_max_unit_tb.sv
